[rtl/gsmt_pkg.sv]
// ----------------------------------------------------------------------------
// gsmt_pkg: shared types and constants for group_sum_max_table
// Field widths, saturation limits and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package gsmt_pkg;

   // default table depth
   localparam int TABLE_ENTRIES_DEF = 64;

   // field widths
   localparam int KEY_W = 32;
   localparam int AMT_W = 32;
   localparam int TOT_W = 48;

   // saturation limits of a running total
   localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
   localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

   // controller to datapath commands
   typedef struct packed {
      logic start;      // capture the request fields, restart the scan
      logic issue;      // issue the next table read while entries remain
      logic update;     // write back the saturated sum of the matched entry
      logic insert;     // append a new entry or flag overflow
      logic scan_clear; // restart the scan pointer and the max tracker
      logic max_acc;    // fold the returned entry into the running maximum
      logic deliver;    // load the result register and clear the table
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic found;      // returned entry matches the captured key
      logic scan_done;  // all entries read and no read in flight
      logic rsp_busy;   // result register still holds an untaken result
      logic last;       // captured record closes the batch
   } status_type;

endpackage

[rtl/gsmt_ctrl.sv]
// ----------------------------------------------------------------------------
// gsmt_ctrl: sequencing state machine
// Steps each record through the key search, the update or insert, and on
// the last record of a batch through the maximum scan and the result load.
// ----------------------------------------------------------------------------
module gsmt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gsmt_pkg::status_type status,
   output gsmt_pkg::cmd_type    cmd
);
   import gsmt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SEARCH  = 4'b0010,
      ST_MAX     = 4'b0100,
      ST_DELIVER = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.issue = 1'b1;
            if (status.found || status.scan_done) begin
               cmd.update     = status.found;
               cmd.insert     = !status.found;
               cmd.scan_clear = 1'b1;
               state_in       = status.last ? ST_MAX : ST_IDLE;
            end
         end
         ST_MAX: begin
            cmd.issue   = 1'b1;
            cmd.max_acc = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!status.rsp_busy) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/gsmt_dp.sv]
// ----------------------------------------------------------------------------
// gsmt_dp: table storage and arithmetic
// Key and total memories scanned one entry a cycle, saturating accumulate,
// running maximum and the result register.
// ----------------------------------------------------------------------------
module gsmt_dp #(
   parameter int TABLE_ENTRIES = gsmt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gsmt_pkg::cmd_type                   cmd,
   output gsmt_pkg::status_type                status,
   input  logic [gsmt_pkg::KEY_W-1:0]          req_sender_id,
   input  logic signed [gsmt_pkg::AMT_W-1:0]   req_amount,
   input  logic                                req_last_record,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gsmt_pkg::KEY_W-1:0]          rsp_top_sender,
   output logic signed [gsmt_pkg::TOT_W-1:0]   rsp_top_total,
   output logic                                rsp_table_overflowed
);
   import gsmt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

   // table memories
   logic [KEY_W-1:0]        key_mem [TABLE_ENTRIES];
   logic signed [TOT_W-1:0] tot_mem [TABLE_ENTRIES];

   // captured record
   logic [KEY_W-1:0]        key_ff;
   logic signed [AMT_W-1:0] amt_ff;
   logic                    last_ff;

   // table control
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] scan_ff, scan_in;

   // read port
   logic                    rd_issue;
   logic                    q_vld_ff, q_vld_in;
   logic [IDX_W-1:0]        q_idx_ff;
   logic [KEY_W-1:0]        key_q_ff;
   logic signed [TOT_W-1:0] tot_q_ff;

   // write port
   logic                    we;
   logic [IDX_W-1:0]        waddr;
   logic signed [TOT_W-1:0] wtot;

   // running maximum
   logic                    have_ff, have_in;
   logic [KEY_W-1:0]        best_key_ff;
   logic signed [TOT_W-1:0] best_tot_ff;
   logic                    take_best;

   // result register
   logic rsp_valid_ff, rsp_valid_in;

   // saturating sum
   logic signed [TOT_W:0]   sum_wide;
   logic signed [TOT_W-1:0] sum_sat;

   assign sum_wide = {tot_q_ff[TOT_W-1], tot_q_ff} + (TOT_W+1)'(amt_ff);

   always_comb begin
      if (sum_wide[TOT_W] != sum_wide[TOT_W-1]) begin
         sum_sat = sum_wide[TOT_W] ? TOT_MIN : TOT_MAX;
      end else begin
         sum_sat = sum_wide[TOT_W-1:0];
      end
   end

   // scan pointer and read issue
   assign rd_issue = cmd.issue && (scan_ff < count_ff);

   always_comb begin
      scan_in  = scan_ff;
      q_vld_in = rd_issue;
      if (cmd.start || cmd.scan_clear) begin
         scan_in  = '0;
         q_vld_in = 1'b0;
      end else if (rd_issue) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   // update, insert and batch clear
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      we       = 1'b0;
      waddr    = q_idx_ff;
      wtot     = sum_sat;
      if (cmd.update) begin
         we = 1'b1;
      end else if (cmd.insert) begin
         if (count_ff < FULL) begin
            we       = 1'b1;
            waddr    = count_ff[IDX_W-1:0];
            wtot     = TOT_W'(amt_ff);
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end else if (cmd.deliver) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         key_mem[waddr] <= key_ff;
         tot_mem[waddr] <= wtot;
      end
      key_q_ff <= key_mem[scan_ff[IDX_W-1:0]];
      tot_q_ff <= tot_mem[scan_ff[IDX_W-1:0]];
      q_idx_ff <= scan_ff[IDX_W-1:0];
   end

   // running maximum, later entries win ties
   assign take_best = cmd.max_acc && q_vld_ff && (!have_ff || (tot_q_ff >= best_tot_ff));

   always_comb begin
      have_in = have_ff;
      if (cmd.scan_clear) begin
         have_in = 1'b0;
      end else if (take_best) begin
         have_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_key_ff <= key_q_ff;
         best_tot_ff <= tot_q_ff;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff  <= req_sender_id;
         amt_ff  <= req_amount;
         last_ff <= req_last_record;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_top_sender       <= have_ff ? best_key_ff : '0;
         rsp_top_total        <= have_ff ? best_tot_ff : '0;
         rsp_table_overflowed <= ovf_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         scan_ff      <= '0;
         q_vld_ff     <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         scan_ff      <= scan_in;
         q_vld_ff     <= q_vld_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status to the controller
   assign status.found     = q_vld_ff && (key_q_ff == key_ff);
   assign status.scan_done = !q_vld_ff && (scan_ff >= count_ff);
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign status.last      = last_ff;

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/group_sum_max_table.sv]
// ----------------------------------------------------------------------------
// group_sum_max_table: per-batch group-by-sum with top sender report
// Accumulates signed amounts per sender id and names the largest total at
// the end of each batch.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one record (sender id, amount, last flag) per transfer.
//   rsp_* carries one result per batch, produced by the record with
//   req_last_record set: the sender with the largest total (latest inserted
//   wins a tie), its 48-bit saturated total and the overflow flag.
//   A record's search stops at the matching entry on a hit and reads every
//   entry on a miss, and the next record is taken only once it ends; the key
//   memory is searched one entry a cycle through its single read port.
//   A last record adds the maximum scan over every entry and then the load
//   of the result register.
//   Reset empties the table, clears the overflow flag and drops any result.
//   The result register parts the channels: records keep flowing while a
//   result waits; only the next batch end stalls until rsp_ready takes it.
// ----------------------------------------------------------------------------
module group_sum_max_table #(
   parameter int TABLE_ENTRIES = gsmt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gsmt_pkg::KEY_W-1:0]          req_sender_id,
   input  logic signed [gsmt_pkg::AMT_W-1:0]   req_amount,
   input  logic                                req_last_record,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gsmt_pkg::KEY_W-1:0]          rsp_top_sender,
   output logic signed [gsmt_pkg::TOT_W-1:0]   rsp_top_total,
   output logic                                rsp_table_overflowed
);
   import gsmt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   gsmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   gsmt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_sender_id        (req_sender_id),
      .req_amount           (req_amount),
      .req_last_record      (req_last_record),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_top_sender       (rsp_top_sender),
      .rsp_top_total        (rsp_top_total),
      .rsp_table_overflowed (rsp_table_overflowed)
   );

   // a record is never both updated and inserted
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.update && cmd.insert))
      else $error("update and insert in the same cycle");

   // a match and an exhausted scan exclude each other
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      !(status.found && status.scan_done))
      else $error("match reported on a finished scan");

   // a result load always shows up on the result channel
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |=> rsp_valid)
      else $error("result load without rsp_valid");

   // after a transfer the block is busy with the search
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after a request transfer");

endmodule
